### rtl/i2cmr_pkg.sv
// ----------------------------------------------------------------------------
// i2cmr_pkg: shared types and constants for the I2C master read sequencer
// Transaction payloads, sequencer phase codes and the state record that
// passes between the sequencer logic and the top level.
// ----------------------------------------------------------------------------
package i2cmr_pkg;

	// Default width of the remaining-byte counter
	localparam int COUNT_WIDTH_DEF = 8;

	localparam int BITS_PER_BYTE = 8;
	localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE);

	// Index of the last bit of a byte
	localparam logic [BIT_IDX_W-1:0] LAST_BIT = BIT_IDX_W'(BITS_PER_BYTE - 1);

	// R/W bit appended to the address: read
	localparam logic RW_READ = 1'b1;

	// Line levels
	localparam logic LINE_HIGH = 1'b1;
	localparam logic LINE_LOW  = 1'b0;

	// Sequencer phases, one pin action per tick
	typedef enum logic [11:0] {
		PH_IDLE      = 12'b0000_0000_0001,
		PH_ADDR_LOW  = 12'b0000_0000_0010,
		PH_ADDR_HIGH = 12'b0000_0000_0100,
		PH_AACK_LOW  = 12'b0000_0000_1000,
		PH_AACK_HIGH = 12'b0000_0001_0000,
		PH_RD_LOW    = 12'b0000_0010_0000,
		PH_RD_HIGH   = 12'b0000_0100_0000,
		PH_RACK_LOW  = 12'b0000_1000_0000,
		PH_RACK_HIGH = 12'b0001_0000_0000,
		PH_STOP_LOW  = 12'b0010_0000_0000,
		PH_STOP_HIGH = 12'b0100_0000_0000,
		PH_STOP_SDA  = 12'b1000_0000_0000
	} phase_t;

	// One input tick
	typedef struct packed {
		logic       start_request;
		logic [6:0] target_address;
		logic [7:0] byte_count;
		logic       sda_sampled;
	} req_t;

	// One result per tick
	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_enable;
		logic [7:0] received_byte;
		logic       byte_valid;
		logic       final_byte;
		logic       ack_error;
		logic       busy_res;
	} res_t;

	// Sequencer state except the byte counter, whose width is a parameter
	typedef struct packed {
		phase_t                 phase;
		logic [BIT_IDX_W-1:0]   bit_index;
		logic [7:0]             rx_shift;
		logic [7:0]             addr_shift;
		logic                   sda_reg;
	} state_t;

endpackage

### rtl/i2cmr_chan.sv
// ----------------------------------------------------------------------------
// i2cmr_chan: valid/ready channel
// Carries one payload per transaction; a transaction completes on a rising
// clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface i2cmr_chan #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

### rtl/i2cmr_seq.sv
// ----------------------------------------------------------------------------
// i2cmr_seq: next-state and result logic of the read sequencer
// Pure combinational step: current state and one input tick give the next
// state and the pin levels and status for that tick.
// ----------------------------------------------------------------------------
module i2cmr_seq #(
	parameter int COUNT_WIDTH = i2cmr_pkg::COUNT_WIDTH_DEF
) (
	input  i2cmr_pkg::state_t       cur,
	input  logic [COUNT_WIDTH-1:0]  bytes_left,
	input  i2cmr_pkg::req_t         tick,
	output i2cmr_pkg::state_t       nxt,
	output logic [COUNT_WIDTH-1:0]  nxt_bytes_left,
	output i2cmr_pkg::res_t         result
);
	import i2cmr_pkg::*;

	logic       scl;
	logic       sda_en;
	logic [7:0] rx_byte;
	logic       rx_valid;
	logic       rx_last;
	logic       err;
	logic       busy;
	logic [7:0] rx_next;
	logic       no_bytes;

	assign rx_next  = {cur.rx_shift[6:0], tick.sda_sampled};
	assign no_bytes = (bytes_left == '0);

	// Phase sequencer
	always_comb begin
		nxt            = cur;
		nxt_bytes_left = bytes_left;
		scl            = LINE_HIGH;
		sda_en         = 1'b0;
		rx_byte        = '0;
		rx_valid       = 1'b0;
		rx_last        = 1'b0;
		err            = 1'b0;
		busy           = 1'b1;
		unique case (cur.phase)
			PH_ADDR_LOW: begin
				scl         = LINE_LOW;
				nxt.sda_reg = cur.addr_shift[7];
				sda_en      = 1'b1;
				nxt.phase   = PH_ADDR_HIGH;
			end
			PH_ADDR_HIGH: begin
				sda_en         = 1'b1;
				nxt.addr_shift = {cur.addr_shift[6:0], 1'b0};
				nxt.phase      = (cur.bit_index == LAST_BIT) ? PH_AACK_LOW : PH_ADDR_LOW;
				nxt.bit_index  = cur.bit_index + 1'b1;
			end
			PH_AACK_LOW: begin
				scl         = LINE_LOW;
				nxt.sda_reg = LINE_HIGH;
				nxt.phase   = PH_AACK_HIGH;
			end
			PH_AACK_HIGH: begin
				nxt.sda_reg = LINE_HIGH;
				if (tick.sda_sampled) begin
					// no address acknowledge: abort, lines released
					err       = 1'b1;
					busy      = 1'b0;
					nxt.phase = PH_IDLE;
				end else begin
					nxt.bit_index = '0;
					nxt.phase     = no_bytes ? PH_STOP_LOW : PH_RD_LOW;
				end
			end
			PH_RD_LOW: begin
				scl         = LINE_LOW;
				nxt.sda_reg = LINE_HIGH;
				nxt.phase   = PH_RD_HIGH;
			end
			PH_RD_HIGH: begin
				nxt.sda_reg  = LINE_HIGH;
				nxt.rx_shift = rx_next;
				if (cur.bit_index == LAST_BIT) begin
					rx_valid       = 1'b1;
					rx_byte        = rx_next;
					rx_last        = (bytes_left == COUNT_WIDTH'(1));
					nxt_bytes_left = bytes_left - COUNT_WIDTH'(1);
					nxt.phase      = PH_RACK_LOW;
				end else begin
					nxt.phase = PH_RD_LOW;
				end
				nxt.bit_index = cur.bit_index + 1'b1;
			end
			PH_RACK_LOW: begin
				// ack (low) unless this was the last byte
				scl         = LINE_LOW;
				nxt.sda_reg = no_bytes;
				sda_en      = 1'b1;
				nxt.phase   = PH_RACK_HIGH;
			end
			PH_RACK_HIGH: begin
				sda_en        = 1'b1;
				nxt.bit_index = '0;
				nxt.phase     = no_bytes ? PH_STOP_LOW : PH_RD_LOW;
			end
			PH_STOP_LOW: begin
				scl         = LINE_LOW;
				nxt.sda_reg = LINE_LOW;
				sda_en      = 1'b1;
				nxt.phase   = PH_STOP_HIGH;
			end
			PH_STOP_HIGH: begin
				nxt.sda_reg = LINE_LOW;
				sda_en      = 1'b1;
				nxt.phase   = PH_STOP_SDA;
			end
			PH_STOP_SDA: begin
				nxt.sda_reg = LINE_HIGH;
				sda_en      = 1'b1;
				nxt.phase   = PH_IDLE;
			end
			default: begin
				// idle, and any code outside the phase set
				if (tick.start_request) begin
					nxt.addr_shift = {tick.target_address, RW_READ};
					nxt_bytes_left = COUNT_WIDTH'(tick.byte_count);
					nxt.bit_index  = '0;
					nxt.rx_shift   = '0;
					nxt.sda_reg    = LINE_LOW;
					sda_en         = 1'b1;
					nxt.phase      = PH_ADDR_LOW;
				end else begin
					nxt.sda_reg = LINE_HIGH;
					busy        = 1'b0;
					nxt.phase   = PH_IDLE;
				end
			end
		endcase
	end

	// Result for this tick; released SDA reads high
	always_comb begin
		result.scl_level     = scl;
		result.sda_level     = sda_en ? nxt.sda_reg : LINE_HIGH;
		result.sda_enable    = sda_en;
		result.received_byte = rx_byte;
		result.byte_valid    = rx_valid;
		result.final_byte    = rx_last;
		result.ack_error     = err;
		result.busy_res      = busy;
	end

endmodule

### rtl/i2c_master_read_bitbang.sv
// ----------------------------------------------------------------------------
// i2c_master_read_bitbang: I2C master read transaction, one half-bit per tick
// Each input transaction is one timing tick; the block answers every tick
// with the SCL/SDA levels and status for it.
// ----------------------------------------------------------------------------
// Every input transaction is one half-bit tick and yields exactly one result
// transaction. The sequencer step is a single pass of combinational logic
// from the state registers into a result register, so a tick is accepted
// every clock cycle as long as the result register is
// empty or being drained in the same cycle; a stalled result stalls input.
// A start request seen while idle captures address and byte count, then the
// block drives start, address+R, samples the address ack, reads the bytes
// with ack/nack and finishes with a stop. A missing address ack flags
// ack_error and returns to idle on that tick with the lines released.
// ----------------------------------------------------------------------------
module i2c_master_read_bitbang #(
	parameter int COUNT_WIDTH = i2cmr_pkg::COUNT_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	i2cmr_chan.sink   req,
	i2cmr_chan.source res
);
	import i2cmr_pkg::*;

	state_t                  state_q;
	logic [COUNT_WIDTH-1:0]  bytes_left_q;
	state_t                  state_nxt;
	logic [COUNT_WIDTH-1:0]  bytes_left_nxt;
	res_t                    res_nxt;
	res_t                    res_q;
	logic                    res_valid_q;
	logic                    req_acc;

	// Input taken whenever the result slot is free or drains now
	assign req.ready = !res_valid_q || res.ready;
	assign req_acc   = req.valid && req.ready;

	i2cmr_seq #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_seq (
		.cur            (state_q),
		.bytes_left     (bytes_left_q),
		.tick           (req.payload),
		.nxt            (state_nxt),
		.nxt_bytes_left (bytes_left_nxt),
		.result         (res_nxt)
	);

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase      <= PH_IDLE;
			state_q.bit_index  <= '0;
			state_q.rx_shift   <= '0;
			state_q.addr_shift <= '0;
			state_q.sda_reg    <= LINE_HIGH;
			bytes_left_q       <= '0;
		end else if (req_acc) begin
			state_q      <= state_nxt;
			bytes_left_q <= bytes_left_nxt;
		end
	end

	// Result register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (req_acc) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (req_acc) begin
			res_q <= res_nxt;
		end
	end

	assign res.valid   = res_valid_q;
	assign res.payload = res_q;

	// Idle with no start stays idle
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && (state_q.phase == PH_IDLE) && !req.payload.start_request
		|=> (state_q.phase == PH_IDLE) && res.valid && !res.payload.busy_res)
		else $error("idle tick without start left idle");

	// Missing address ack aborts to idle with an error result
	a_nack_abort: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && (state_q.phase == PH_AACK_HIGH) && req.payload.sda_sampled
		|=> (state_q.phase == PH_IDLE) && res.payload.ack_error
			&& !res.payload.busy_res)
		else $error("address nack did not abort");

	// Eighth read bit produces a byte
	a_byte_done: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && (state_q.phase == PH_RD_HIGH) && (state_q.bit_index == LAST_BIT)
		|=> res.valid && res.payload.byte_valid
			&& (state_q.phase == PH_RACK_LOW))
		else $error("completed byte not reported");

	// A pending byte result means the sequencer waits to send ack/nack
	a_byte_phase: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.payload.byte_valid |-> (state_q.phase == PH_RACK_LOW))
		else $error("byte result out of step with sequencer");

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the I2C master read sequencer
// Feeds half-bit ticks through the request channel: whole read transactions
// with random target data, address nacks, zero and maximum byte counts,
// start requests while busy and idle noise. A tick-level model of the
// sequencer predicts the pin levels and status for every tick. Each result
// is compared field by field as it drains from the result channel.
// ----------------------------------------------------------------------------
module testbench;
	import i2cmr_pkg::*;

	localparam int QUIET_LIMIT = 1000;
	localparam int IDLE_MAX    = 18;
	localparam int HOLD_AT     = 200;
	localparam int HOLD_LEN    = 150;
	localparam int SETTLE      = 10;
	localparam int TICK_TARGET = 750;

	typedef struct {
		req_t tick;
		int   lead;
		bit   drain;
	} send_item_t;

	logic clk = 1'b0;
	logic arst_n;

	i2cmr_chan #(.payload_t(req_t)) req_if ();
	i2cmr_chan #(.payload_t(res_t)) res_if ();

	i2c_master_read_bitbang DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.res(res_if)
	);

	always #1 clk = ~clk;

	send_item_t ticks_to_send[$];
	res_t       levels_due[$];
	int         tick_total;
	int         errors;
	int         quiet;
	int         results_seen;
	int         rx_stall;
	int         hold_left;

	// Model state of the sequencer
	phase_t               m_phase;
	logic [BIT_IDX_W-1:0] m_bit;
	logic [7:0]           m_left;
	logic [7:0]           m_rx;
	logic [7:0]           m_addr;
	logic                 m_scl;
	logic                 m_sda;

	task automatic clear_model();
		m_phase = PH_IDLE;
		m_bit   = '0;
		m_left  = '0;
		m_rx    = '0;
		m_addr  = '0;
		m_scl   = LINE_HIGH;
		m_sda   = LINE_HIGH;
	endtask

	// Advance the model one tick and queue the pin levels it produces
	task automatic sequence_tick(input req_t t);
		res_t r;
		logic drive;
		r = '0;
		drive = 1'b0;
		r.busy_res = 1'b1;
		case (m_phase)
			PH_ADDR_LOW: begin
				m_scl = LINE_LOW;
				m_sda = m_addr[7];
				drive = 1'b1;
				m_phase = PH_ADDR_HIGH;
			end
			PH_ADDR_HIGH: begin
				m_scl = LINE_HIGH;
				drive = 1'b1;
				m_addr = {m_addr[6:0], 1'b0};
				m_phase = (m_bit == LAST_BIT) ? PH_AACK_LOW : PH_ADDR_LOW;
				m_bit = m_bit + 1'b1;
			end
			PH_AACK_LOW: begin
				m_scl = LINE_LOW;
				m_sda = LINE_HIGH;
				m_phase = PH_AACK_HIGH;
			end
			PH_AACK_HIGH: begin
				m_scl = LINE_HIGH;
				m_sda = LINE_HIGH;
				if (t.sda_sampled) begin
					// no address ack: flag it and drop back to idle
					r.ack_error = 1'b1;
					r.busy_res = 1'b0;
					m_phase = PH_IDLE;
				end else begin
					m_bit = '0;
					m_phase = (m_left == 0) ? PH_STOP_LOW : PH_RD_LOW;
				end
			end
			PH_RD_LOW: begin
				m_scl = LINE_LOW;
				m_sda = LINE_HIGH;
				m_phase = PH_RD_HIGH;
			end
			PH_RD_HIGH: begin
				m_scl = LINE_HIGH;
				m_sda = LINE_HIGH;
				m_rx = {m_rx[6:0], t.sda_sampled};
				if (m_bit == LAST_BIT) begin
					r.byte_valid = 1'b1;
					r.received_byte = m_rx;
					r.final_byte = (m_left == 8'd1);
					m_left = m_left - 1'b1;
					m_phase = PH_RACK_LOW;
				end else begin
					m_phase = PH_RD_LOW;
				end
				m_bit = m_bit + 1'b1;
			end
			PH_RACK_LOW: begin
				// ack while bytes remain, nack after the last one
				m_scl = LINE_LOW;
				m_sda = (m_left == 0) ? LINE_HIGH : LINE_LOW;
				drive = 1'b1;
				m_phase = PH_RACK_HIGH;
			end
			PH_RACK_HIGH: begin
				m_scl = LINE_HIGH;
				drive = 1'b1;
				m_bit = '0;
				m_phase = (m_left == 0) ? PH_STOP_LOW : PH_RD_LOW;
			end
			PH_STOP_LOW: begin
				m_scl = LINE_LOW;
				m_sda = LINE_LOW;
				drive = 1'b1;
				m_phase = PH_STOP_HIGH;
			end
			PH_STOP_HIGH: begin
				m_scl = LINE_HIGH;
				m_sda = LINE_LOW;
				drive = 1'b1;
				m_phase = PH_STOP_SDA;
			end
			PH_STOP_SDA: begin
				m_scl = LINE_HIGH;
				m_sda = LINE_HIGH;
				drive = 1'b1;
				m_phase = PH_IDLE;
			end
			default: begin
				m_scl = LINE_HIGH;
				if (t.start_request) begin
					m_addr = {t.target_address, RW_READ};
					m_left = t.byte_count;
					m_bit = '0;
					m_rx = '0;
					m_sda = LINE_LOW;
					drive = 1'b1;
					m_phase = PH_ADDR_LOW;
				end else begin
					m_sda = LINE_HIGH;
					r.busy_res = 1'b0;
					m_phase = PH_IDLE;
				end
			end
		endcase
		r.scl_level = m_scl;
		r.sda_level = drive ? m_sda : LINE_HIGH;
		r.sda_enable = drive;
		levels_due.push_back(r);
	endtask

	// Stimulus building
	function automatic req_t noise_tick(input bit busy_noise);
		req_t t;
		t.start_request = busy_noise && ($urandom_range(0, 3) == 0);
		t.target_address = 7'($urandom);
		t.byte_count = 8'($urandom);
		t.sda_sampled = 1'($urandom);
		return t;
	endfunction

	task automatic queue_tick(input req_t t, input bit idle_on, input bit drain);
		send_item_t s;
		s.tick = t;
		s.lead = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
		s.drain = drain;
		ticks_to_send.push_back(s);
		tick_total++;
	endtask

	// One read transaction; fill < 0 gives random target data
	task automatic queue_read(input logic [6:0] addr, input logic [7:0] count,
			input bit ack_ok, input bit busy_noise, input int fill,
			input bit idle_on, input bit drain);
		req_t t;
		t = noise_tick(busy_noise);
		t.start_request = 1'b1;
		t.target_address = addr;
		t.byte_count = count;
		queue_tick(t, idle_on, drain);
		// address bits plus the low half of the ack slot
		repeat (2 * BITS_PER_BYTE + 1) queue_tick(noise_tick(busy_noise), idle_on, 1'b0);
		t = noise_tick(busy_noise);
		t.sda_sampled = !ack_ok;
		queue_tick(t, idle_on, 1'b0);
		if (ack_ok) begin
			for (int b = 0; b < count; b++) begin
				for (int k = BITS_PER_BYTE - 1; k >= 0; k--) begin
					queue_tick(noise_tick(busy_noise), idle_on, 1'b0);
					t = noise_tick(busy_noise);
					if (fill >= 0)
						t.sda_sampled = fill[k];
					queue_tick(t, idle_on, 1'b0);
				end
				repeat (2) queue_tick(noise_tick(busy_noise), idle_on, 1'b0);
			end
			repeat (3) queue_tick(noise_tick(busy_noise), idle_on, 1'b0);
		end
	endtask

	task automatic check_field(input string what, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s expected %0h got %0h", $time, what, want, got);
		end
	endtask

	// Request driver: offers queued ticks, honoring lead gaps and drains
	always @(posedge clk or negedge arst_n) begin : driver
		if (!arst_n) begin
			req_if.valid <= 1'b0;
			req_if.payload <= '0;
			clear_model();
		end else begin
			if (req_if.valid && req_if.ready)
				sequence_tick(req_if.payload);
			if (!req_if.valid || req_if.ready) begin
				if (ticks_to_send.size() == 0) begin
					req_if.valid <= 1'b0;
				end else if (ticks_to_send[0].lead > 0) begin
					ticks_to_send[0].lead = ticks_to_send[0].lead - 1;
					req_if.valid <= 1'b0;
				end else if (ticks_to_send[0].drain && levels_due.size() != 0) begin
					req_if.valid <= 1'b0;
				end else begin
					req_if.valid <= 1'b1;
					req_if.payload <= ticks_to_send[0].tick;
					void'(ticks_to_send.pop_front());
				end
			end
		end
	end

	// Result monitor: checks each result and paces ready
	always @(posedge clk or negedge arst_n) begin : monitor
		int   stall_now;
		res_t want;
		res_t got;
		if (!arst_n) begin
			res_if.ready <= 1'b0;
			rx_stall = 0;
			hold_left = 0;
			results_seen = 0;
		end else begin
			stall_now = rx_stall;
			if (res_if.valid && res_if.ready) begin
				got = res_if.payload;
				if (levels_due.size() == 0) begin
					errors++;
					$display("%0t: result with no tick pending, got %0h", $time, got);
				end else begin
					want = levels_due.pop_front();
					check_field("scl_level", want.scl_level, got.scl_level);
					check_field("sda_level", want.sda_level, got.sda_level);
					check_field("sda_enable", want.sda_enable, got.sda_enable);
					check_field("received_byte", want.received_byte, got.received_byte);
					check_field("byte_valid", want.byte_valid, got.byte_valid);
					check_field("final_byte", want.final_byte, got.final_byte);
					check_field("ack_error", want.ack_error, got.ack_error);
					check_field("busy_res", want.busy_res, got.busy_res);
				end
				results_seen++;
				// stretches of back-to-back draining between stalled ones
				stall_now = ((results_seen / 64) % 3 != 0) ? $urandom_range(0, IDLE_MAX) : 0;
				if (results_seen == HOLD_AT)
					hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				rx_stall = stall_now;
				res_if.ready <= 1'b0;
			end else if (stall_now > 0) begin
				rx_stall = stall_now - 1;
				res_if.ready <= 1'b0;
			end else begin
				rx_stall = 0;
				res_if.ready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if (!arst_n || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// Stimulus, reset and end of run
	initial begin
		req_t t;
		int   txn;
		int   pick;
		bit   ack_ok;
		logic [7:0] count;
		req_if.valid = 1'b0;
		req_if.payload = '0;
		res_if.ready = 1'b0;
		arst_n = 1'b0;
		errors = 0;
		quiet = 0;
		tick_total = 0;

		// idle ticks with every field at its extremes, no start
		t = '1;
		t.start_request = 1'b0;
		queue_tick(t, 1'b0, 1'b0);
		queue_tick('0, 1'b0, 1'b0);
		// address nack at address zero
		queue_read(7'h00, 8'd0, 1'b0, 1'b0, -1, 1'b0, 1'b0);
		// zero byte count goes straight to stop, starts while busy
		queue_read(7'h7F, 8'd0, 1'b1, 1'b1, -1, 1'b0, 1'b0);
		// single bytes of all ones and all zeros, back to back
		queue_read(7'h2A, 8'd1, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b0);
		queue_read(7'h55, 8'd1, 1'b1, 1'b0, 8'h00, 1'b1, 1'b0);
		// maximum count with a nack, then a longer read after a drain
		queue_read(7'h55, 8'd255, 1'b0, 1'b1, -1, 1'b1, 1'b0);
		queue_read(7'($urandom), 8'd16, 1'b1, 1'b1, -1, 1'b1, 1'b1);

		// random transactions, mostly short well-formed reads
		txn = 0;
		while (tick_total < TICK_TARGET) begin
			pick = $urandom_range(0, 9);
			if (pick < 2) begin
				repeat ($urandom_range(1, 3))
					queue_tick(noise_tick(1'b0), (txn % 4) != 3, 1'b0);
			end else begin
				ack_ok = ($urandom_range(0, 5) != 0);
				if (!ack_ok)
					count = 8'($urandom);
				else if (pick == 2)
					count = 8'd0;
				else if (pick == 9)
					count = 8'($urandom_range(4, 8));
				else
					count = 8'($urandom_range(1, 3));
				queue_read(7'($urandom), count, ack_ok, 1'($urandom), -1,
					(txn % 4) != 3, (txn % 7) == 0);
			end
			txn++;
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (ticks_to_send.size() != 0 || req_if.valid || levels_due.size() != 0);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
